@@ sv/implant_decay_pixel_correlator_macros.svh @@
// assertion macros used by the checker file
// depends on nothing; included by bare file name
`ifndef IMPLANT_DECAY_PIXEL_CORRELATOR_MACROS_SVH
`define IMPLANT_DECAY_PIXEL_CORRELATOR_MACROS_SVH

// same-cycle implication
`define IDPC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define IDPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ sv/idpc_pkg.sv @@
// shared constants, state and control types of the pixel correlator
// depends on nothing
`timescale 1ns / 1ps

package idpc_pkg;
  localparam int STRIPS  = 40;
  localparam int PIXELS  = STRIPS * STRIPS;
  localparam int IDX_W   = $clog2(PIXELS);
  localparam int COORD_W = 6;
  localparam int STAMP_W = 48;

  localparam logic OP_IMPLANT = 1'b0;
  localparam logic OP_DECAY   = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_IMP_RD,
    S_IMP_WR,
    S_DEC_SCAN,
    S_DEC_DRAIN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic take_item;
    logic imp_rd;
    logic imp_wr;
    logic scan_step;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_last;
    logic out_free;
  } status_t;
endpackage

@@ sv/idpc_if.sv @@
// valid/ready channel interfaces for event items and results
// depends on idpc_pkg
`timescale 1ns / 1ps

interface idpc_item_if;
  import idpc_pkg::*;
  logic               valid;
  logic               ready;
  logic               op;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [STAMP_W-1:0] stamp;

  modport source (output valid, op, row, col, stamp, input ready);
  modport sink (input valid, op, row, col, stamp, output ready);
endinterface

interface idpc_result_if;
  import idpc_pkg::*;
  logic               valid;
  logic               ready;
  logic               is_decay;
  logic               matched;
  logic               own_pixel_hit;
  logic [COORD_W-1:0] best_row;
  logic [COORD_W-1:0] best_col;
  logic [STAMP_W-1:0] delay;
  logic               was_occupied;
  logic [STAMP_W-1:0] previous_stamp;

  modport source (output valid, is_decay, matched, own_pixel_hit, best_row, best_col, delay,
                  was_occupied, previous_stamp, input ready);
  modport sink (input valid, is_decay, matched, own_pixel_hit, best_row, best_col, delay,
                was_occupied, previous_stamp, output ready);
endinterface

@@ sv/idpc_datapath.sv @@
// pixel memory, neighbourhood scan, best-match tracking and result register
// depends on idpc_pkg
`timescale 1ns / 1ps

module idpc_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  idpc_pkg::cmd_t              cmd,
  output idpc_pkg::status_t           status,
  input  logic                        in_op,
  input  logic [idpc_pkg::COORD_W-1:0] in_row,
  input  logic [idpc_pkg::COORD_W-1:0] in_col,
  input  logic [idpc_pkg::STAMP_W-1:0] in_stamp,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_is_decay,
  output logic                        out_matched,
  output logic                        out_own_pixel_hit,
  output logic [idpc_pkg::COORD_W-1:0] out_best_row,
  output logic [idpc_pkg::COORD_W-1:0] out_best_col,
  output logic [idpc_pkg::STAMP_W-1:0] out_delay,
  output logic                        out_was_occupied,
  output logic [idpc_pkg::STAMP_W-1:0] out_previous_stamp
);
  import idpc_pkg::*;

  localparam logic [COORD_W:0] STRIPS_N = (COORD_W+1)'(STRIPS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXELS - 1);

  function automatic logic [IDX_W-1:0] pixel_index(input logic [COORD_W-1:0] r,
                                                   input logic [COORD_W-1:0] c);
    pixel_index = IDX_W'(IDX_W'(r) * IDX_W'(STRIPS) + IDX_W'(c));
  endfunction

  // word is {valid, stamp}
  logic [STAMP_W:0] mem [PIXELS];
  logic [STAMP_W:0] rdata;
  logic             mem_re;
  logic             mem_we;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic [STAMP_W:0] wdata;

  logic               it_op;
  logic [COORD_W-1:0] it_row;
  logic [COORD_W-1:0] it_col;
  logic [STAMP_W-1:0] it_stamp;
  logic               it_on_grid;
  logic [IDX_W-1:0]   it_idx;

  logic [IDX_W-1:0] clr_idx;
  logic [1:0]       dr;
  logic [1:0]       dc;
  logic [COORD_W:0] nb_r;
  logic [COORD_W:0] nb_c;
  logic             nb_on;
  logic [IDX_W-1:0] nb_idx;

  logic               ev_en;
  logic               ev_use;
  logic               ev_own;
  logic [COORD_W-1:0] ev_r;
  logic [COORD_W-1:0] ev_c;

  logic               found;
  logic               own;
  logic [COORD_W-1:0] best_r;
  logic [COORD_W-1:0] best_c;
  logic [STAMP_W-1:0] best_dt;
  logic               occ;
  logic [STAMP_W-1:0] prev;

  logic [STAMP_W-1:0] dt;
  logic               earlier;
  logic               better;

  assign it_on_grid = (it_row < COORD_W'(STRIPS)) && (it_col < COORD_W'(STRIPS));
  assign it_idx     = pixel_index(it_row, it_col);

  // neighbour position, minus one wraps to an off-grid value
  assign nb_r   = {1'b0, it_row} + {{(COORD_W-1){1'b0}}, dr} - (COORD_W+1)'(1);
  assign nb_c   = {1'b0, it_col} + {{(COORD_W-1){1'b0}}, dc} - (COORD_W+1)'(1);
  assign nb_on  = (nb_r < STRIPS_N) && (nb_c < STRIPS_N);
  assign nb_idx = pixel_index(nb_r[COORD_W-1:0], nb_c[COORD_W-1:0]);

  assign mem_re = cmd.imp_rd || cmd.scan_step;
  assign raddr  = cmd.imp_rd ? it_idx : nb_idx;
  assign mem_we = cmd.clear_wr || (cmd.imp_wr && it_on_grid);
  assign waddr  = cmd.clear_wr ? clr_idx : it_idx;
  assign wdata  = cmd.clear_wr ? '0 : {1'b1, it_stamp};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  assign dt      = it_stamp - rdata[STAMP_W-1:0];
  assign earlier = ev_use && rdata[STAMP_W] && (it_stamp > rdata[STAMP_W-1:0]);
  assign better  = !found || (dt < best_dt);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear_wr) begin
      clr_idx <= clr_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      it_op    <= in_op;
      it_row   <= in_row;
      it_col   <= in_col;
      it_stamp <= in_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dr    <= '0;
      dc    <= '0;
      ev_en <= 1'b0;
    end else begin
      ev_en <= cmd.scan_step;
      if (cmd.take_item) begin
        dr <= '0;
        dc <= '0;
      end else if (cmd.scan_step) begin
        if (dc == 2'd2) begin
          dc <= '0;
          dr <= dr + 2'd1;
        end else begin
          dc <= dc + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      ev_use <= nb_on;
      ev_own <= (dr == 2'd1) && (dc == 2'd1);
      ev_r   <= nb_r[COORD_W-1:0];
      ev_c   <= nb_c[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      found   <= 1'b0;
      own     <= 1'b0;
      best_r  <= '0;
      best_c  <= '0;
      best_dt <= '0;
      occ     <= 1'b0;
      prev    <= '0;
    end else begin
      if (ev_en && earlier) begin
        if (ev_own) begin
          own <= 1'b1;
        end
        if (better) begin
          found   <= 1'b1;
          best_r  <= ev_r;
          best_c  <= ev_c;
          best_dt <= dt;
        end
      end
      if (cmd.imp_wr && it_on_grid && rdata[STAMP_W]) begin
        occ  <= 1'b1;
        prev <= rdata[STAMP_W-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_is_decay       <= (it_op == OP_DECAY);
      out_matched        <= found;
      out_own_pixel_hit  <= own;
      out_best_row       <= best_r;
      out_best_col       <= best_c;
      out_delay          <= best_dt;
      out_was_occupied   <= occ;
      out_previous_stamp <= prev;
    end
  end

  assign status.clear_last = (clr_idx == LAST_IDX);
  assign status.scan_last  = (dr == 2'd2) && (dc == 2'd2);
  assign status.out_free   = !out_valid || out_ready;
endmodule

@@ sv/idpc_controller.sv @@
// sequencing state machine for clear, implant and decay handling
// depends on idpc_pkg
`timescale 1ns / 1ps

module idpc_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  input  idpc_pkg::status_t status,
  output idpc_pkg::cmd_t    cmd
);
  import idpc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_next    = (in_op == OP_DECAY) ? S_DEC_SCAN : S_IMP_RD;
        end
      end
      S_IMP_RD: begin
        cmd.imp_rd = 1'b1;
        state_next = S_IMP_WR;
      end
      S_IMP_WR: begin
        cmd.imp_wr = 1'b1;
        state_next = S_FIN;
      end
      S_DEC_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = S_DEC_DRAIN;
        end
      end
      S_DEC_DRAIN: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

@@ sv/implant_decay_pixel_correlator.sv @@
// implant/decay correlator top: an implant passes IMP_RD, IMP_WR and FIN, a decay
// DEC_SCAN (nine neighbour reads through the single read port of the pixel memory),
// DEC_DRAIN and FIN; FIN waits for a free result register, and only IDLE takes items
// after reset a clearing pass empties the pixel map; no item is taken then
// depends on idpc_pkg, idpc_if, idpc_controller, idpc_datapath
`timescale 1ns / 1ps

module implant_decay_pixel_correlator (
  input logic           clk,
  input logic           rst,
  idpc_item_if.sink     item,
  idpc_result_if.source result
);
  import idpc_pkg::*;

  cmd_t    cmd;
  status_t status;

  idpc_controller u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_op    (item.op),
    .in_ready (item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  idpc_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .in_op              (item.op),
    .in_row             (item.row),
    .in_col             (item.col),
    .in_stamp           (item.stamp),
    .out_valid          (result.valid),
    .out_ready          (result.ready),
    .out_is_decay       (result.is_decay),
    .out_matched        (result.matched),
    .out_own_pixel_hit  (result.own_pixel_hit),
    .out_best_row       (result.best_row),
    .out_best_col       (result.best_col),
    .out_delay          (result.delay),
    .out_was_occupied   (result.was_occupied),
    .out_previous_stamp (result.previous_stamp)
  );
endmodule

@@ sv/idpc_checker.sv @@
// port-level checks of the correlator, bound to the top level
// depends on idpc_pkg and the macros header
`timescale 1ns / 1ps
`include "implant_decay_pixel_correlator_macros.svh"

module idpc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_ready,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic                        is_decay,
  input logic                        matched,
  input logic                        own_pixel_hit,
  input logic [idpc_pkg::STAMP_W-1:0] delay,
  input logic                        was_occupied,
  input logic [idpc_pkg::STAMP_W-1:0] previous_stamp
);
  import idpc_pkg::*;

  logic [1:0] pending;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = item_valid && item_ready;
  assign out_xfer = result_valid && result_ready;

  // items taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending <= pending + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pending <= pending - 2'd1;
    end
  end

  `IDPC_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable({is_decay, matched, own_pixel_hit, delay, was_occupied, previous_stamp}))
  `IDPC_ASSERT_IMPLY(a_no_spurious_result, clk, rst, result_valid, pending != 2'd0)
  `IDPC_ASSERT_IMPLY(a_implant_fields, clk, rst, result_valid && !is_decay, !matched && !own_pixel_hit && delay == '0)
  `IDPC_ASSERT_IMPLY(a_decay_fields, clk, rst, result_valid && is_decay, !was_occupied && previous_stamp == '0 && (matched || (!own_pixel_hit && delay == '0)))
endmodule

bind implant_decay_pixel_correlator idpc_checker u_idpc_checker (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item.valid),
  .item_ready     (item.ready),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .is_decay       (result.is_decay),
  .matched        (result.matched),
  .own_pixel_hit  (result.own_pixel_hit),
  .delay          (result.delay),
  .was_occupied   (result.was_occupied),
  .previous_stamp (result.previous_stamp)
);

@@ tb/tb_implant_decay_pixel_correlator.sv @@
// self-checking bench for the implant/decay pixel correlator: directed table, then random
// clustered event traffic, each result checked against the table or a pixel-map predictor
// depends on idpc_pkg, idpc_if and the implant_decay_pixel_correlator rtl
`timescale 1ns / 1ps

module tb_implant_decay_pixel_correlator;
  import idpc_pkg::*;

  localparam int                 WATCHDOG_LIMIT = 8000;
  localparam logic [STAMP_W-1:0] STAMP_MAX      = '1;

  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [STAMP_W-1:0] stamp;
  } pixel_event_t;

  typedef struct packed {
    logic               is_decay;
    logic               matched;
    logic               own_pixel_hit;
    logic [COORD_W-1:0] best_row;
    logic [COORD_W-1:0] best_col;
    logic [STAMP_W-1:0] delay;
    logic               was_occupied;
    logic [STAMP_W-1:0] previous_stamp;
  } outcome_t;

  typedef struct packed {
    pixel_event_t ev;
    logic         typed;
    outcome_t     want;
  } directed_row_t;

  localparam outcome_t PREDICT          = '0;
  localparam outcome_t IMPLANT_FRESH    = '0;
  localparam outcome_t DECAY_EMPTY      = '{is_decay: 1'b1, default: '0};
  localparam outcome_t OCCUPIED_AT_ZERO = '{was_occupied: 1'b1, default: '0};
  localparam outcome_t OCCUPIED_AT_MAX  = '{was_occupied: 1'b1, previous_stamp: STAMP_MAX,
                                            default: '0};

  localparam directed_row_t DIRECTED [24] = '{
    '{'{OP_DECAY,   6'd5,  6'd5,  48'd100},   1'b1, DECAY_EMPTY},
    '{'{OP_IMPLANT, 6'd5,  6'd5,  48'd0},     1'b1, IMPLANT_FRESH},
    '{'{OP_IMPLANT, 6'd5,  6'd5,  48'd10},    1'b1, OCCUPIED_AT_ZERO},
    '{'{OP_IMPLANT, 6'd4,  6'd4,  48'd20},    1'b1, IMPLANT_FRESH},
    '{'{OP_IMPLANT, 6'd4,  6'd6,  48'd20},    1'b1, IMPLANT_FRESH},
    '{'{OP_DECAY,   6'd5,  6'd5,  48'd22},    1'b0, PREDICT},
    '{'{OP_IMPLANT, 6'd6,  6'd6,  48'd25},    1'b1, IMPLANT_FRESH},
    '{'{OP_DECAY,   6'd5,  6'd5,  48'd25},    1'b0, PREDICT},
    '{'{OP_DECAY,   6'd4,  6'd5,  48'd0},     1'b1, DECAY_EMPTY},
    '{'{OP_IMPLANT, 6'd0,  6'd0,  48'd30},    1'b1, IMPLANT_FRESH},
    '{'{OP_DECAY,   6'd0,  6'd0,  48'd31},    1'b0, PREDICT},
    '{'{OP_IMPLANT, 6'd39, 6'd39, 48'd32},    1'b1, IMPLANT_FRESH},
    '{'{OP_DECAY,   6'd39, 6'd39, 48'd40},    1'b0, PREDICT},
    '{'{OP_IMPLANT, 6'd40, 6'd5,  48'd41},    1'b1, IMPLANT_FRESH},
    '{'{OP_IMPLANT, 6'd63, 6'd63, 48'd42},    1'b1, IMPLANT_FRESH},
    '{'{OP_DECAY,   6'd40, 6'd39, 48'd50},    1'b0, PREDICT},
    '{'{OP_DECAY,   6'd63, 6'd63, 48'd50},    1'b1, DECAY_EMPTY},
    '{'{OP_IMPLANT, 6'd40, 6'd5,  48'd60},    1'b1, IMPLANT_FRESH},
    '{'{OP_IMPLANT, 6'd20, 6'd20, STAMP_MAX}, 1'b1, IMPLANT_FRESH},
    '{'{OP_IMPLANT, 6'd20, 6'd20, 48'd0},     1'b1, OCCUPIED_AT_MAX},
    '{'{OP_DECAY,   6'd20, 6'd20, STAMP_MAX}, 1'b0, PREDICT},
    '{'{OP_IMPLANT, 6'd0,  6'd39, 48'd70},    1'b1, IMPLANT_FRESH},
    '{'{OP_DECAY,   6'd1,  6'd38, 48'd80},    1'b0, PREDICT},
    '{'{OP_DECAY,   6'd39, 6'd0,  48'd90},    1'b1, DECAY_EMPTY}
  };

  logic clk = 1'b0;
  logic rst;

  idpc_item_if   item ();
  idpc_result_if result ();

  implant_decay_pixel_correlator u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result)
  );

  always #6 clk = ~clk;

  logic [STAMP_W-1:0] implant_time [PIXELS];
  bit                 pixel_busy   [PIXELS];
  outcome_t           correlation_q [$];
  int                 mismatches  = 0;
  int                 idle_cycles = 0;
  int                 burst_left  = 0;
  int                 rx_mode     = 1;
  bit                 steady      = 1'b0;
  logic [STAMP_W-1:0] event_time;
  int                 hot_row [4];
  int                 hot_col [4];

  function automatic outcome_t correlate(input pixel_event_t ev);
    outcome_t           res;
    int                 idx;
    int                 r;
    int                 c;
    logic [STAMP_W-1:0] dt;
    res = '0;
    if (ev.op == OP_IMPLANT) begin
      if (ev.row < STRIPS && ev.col < STRIPS) begin
        idx = ev.row * STRIPS + ev.col;
        if (pixel_busy[idx]) begin
          res.was_occupied   = 1'b1;
          res.previous_stamp = implant_time[idx];
        end
        implant_time[idx] = ev.stamp;
        pixel_busy[idx]   = 1'b1;
      end
    end else begin
      res.is_decay = 1'b1;
      for (r = int'(ev.row) - 1; r <= int'(ev.row) + 1; r++) begin
        for (c = int'(ev.col) - 1; c <= int'(ev.col) + 1; c++) begin
          if (r < 0 || r >= STRIPS || c < 0 || c >= STRIPS) continue;
          idx = r * STRIPS + c;
          if (!pixel_busy[idx] || !(ev.stamp > implant_time[idx])) continue;
          if (r == int'(ev.row) && c == int'(ev.col)) res.own_pixel_hit = 1'b1;
          dt = ev.stamp - implant_time[idx];
          // strict less-than: first scanned wins a tie
          if (!res.matched || dt < res.delay) begin
            res.matched  = 1'b1;
            res.delay    = dt;
            res.best_row = r[COORD_W-1:0];
            res.best_col = c[COORD_W-1:0];
          end
        end
      end
    end
    return res;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(input int hot);
    int k;
    int v;
    k = $urandom_range(0, 99);
    if (k < 70) begin
      v = hot + int'($urandom_range(0, 2)) - 1;
      if (v < 0) v = 0;
    end else if (k < 86) begin
      v = $urandom_range(0, STRIPS - 1);
    end else if (k < 96) begin
      v = ($urandom_range(0, 1) != 0) ? STRIPS - 1 : 0;
    end else begin
      v = $urandom_range(STRIPS, 63);
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic pixel_event_t random_event();
    pixel_event_t ev;
    int           h;
    int           k;
    logic [63:0]  wide;
    h = $urandom_range(0, 3);
    k = $urandom_range(0, 99);
    if (k < 15) begin
      // same time as the previous event
    end else if (k < 80) begin
      event_time = event_time + STAMP_W'($urandom_range(1, 40));
    end else if (k < 95) begin
      event_time = event_time + STAMP_W'($urandom_range(41, 100000));
    end else begin
      wide       = {$urandom(), $urandom()};
      event_time = wide[STAMP_W-1:0];
    end
    ev.op    = ($urandom_range(0, 99) < 55) ? OP_IMPLANT : OP_DECAY;
    ev.row   = pick_coord(hot_row[h]);
    ev.col   = pick_coord(hot_col[h]);
    ev.stamp = event_time;
    return ev;
  endfunction

  task automatic report_mismatch(input string field, input logic [STAMP_W-1:0] got,
                                 input logic [STAMP_W-1:0] want);
    $display("mismatch %s: got %0h want %0h", field, got, want);
    mismatches++;
  endtask

  task automatic send_event(input pixel_event_t ev, input logic typed, input outcome_t want);
    int       gap;
    outcome_t model_out;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.valid <= 1'b1;
    item.op    <= ev.op;
    item.row   <= ev.row;
    item.col   <= ev.col;
    item.stamp <= ev.stamp;
    do @(posedge clk); while (item.ready !== 1'b1);
    model_out = correlate(ev);
    correlation_q.insert(correlation_q.size(), typed ? want : model_out);
  endtask

  task automatic drain();
    @(negedge clk);
    item.valid <= 1'b0;
    while (correlation_q.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int k;
    int ph;
    int n;
    rst        = 1'b1;
    item.valid = 1'b0;
    item.op    = OP_IMPLANT;
    item.row   = '0;
    item.col   = '0;
    item.stamp = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (k = 0; k < $size(DIRECTED); k++) begin
      send_event(DIRECTED[k].ev, DIRECTED[k].typed, DIRECTED[k].want);
    end
    drain();
    event_time = 48'd1000;
    for (ph = 0; ph < 6; ph++) begin
      steady  = (ph == 2 || ph == 5);
      rx_mode = ph % 3;
      for (k = 0; k < 4; k++) begin
        hot_row[k] = $urandom_range(0, STRIPS - 1);
        hot_col[k] = $urandom_range(0, STRIPS - 1);
      end
      for (n = 0; n < 242; n++) send_event(random_event(), 1'b0, PREDICT);
      drain();
    end
    repeat (40) @(posedge clk);
    if (mismatches == 0 && correlation_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : sink_pacing
    int tick;
    tick         = 0;
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      case (rx_mode)
        0: begin
          result.ready <= 1'b1;
        end
        1: begin
          result.ready <= ($urandom_range(0, 2) != 0);
        end
        default: begin
          result.ready <= ((tick % 23) >= 9);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (!rst && result.valid === 1'b1 && result.ready === 1'b1) begin
      got.is_decay       = result.is_decay;
      got.matched        = result.matched;
      got.own_pixel_hit  = result.own_pixel_hit;
      got.best_row       = result.best_row;
      got.best_col       = result.best_col;
      got.delay          = result.delay;
      got.was_occupied   = result.was_occupied;
      got.previous_stamp = result.previous_stamp;
      if (correlation_q.size() == 0) begin
        report_mismatch("result with none awaited", '0, '0);
      end else begin
        want = correlation_q.pop_front();
        if (got.is_decay !== want.is_decay)
          report_mismatch("is_decay", got.is_decay, want.is_decay);
        if (got.matched !== want.matched)
          report_mismatch("matched", got.matched, want.matched);
        if (got.own_pixel_hit !== want.own_pixel_hit)
          report_mismatch("own_pixel_hit", got.own_pixel_hit, want.own_pixel_hit);
        if (got.best_row !== want.best_row)
          report_mismatch("best_row", got.best_row, want.best_row);
        if (got.best_col !== want.best_col)
          report_mismatch("best_col", got.best_col, want.best_col);
        if (got.delay !== want.delay)
          report_mismatch("delay", got.delay, want.delay);
        if (got.was_occupied !== want.was_occupied)
          report_mismatch("was_occupied", got.was_occupied, want.was_occupied);
        if (got.previous_stamp !== want.previous_stamp)
          report_mismatch("previous_stamp", got.previous_stamp, want.previous_stamp);
      end
    end
  end

  // covers reset plus the map clearing pass with wide margin
  always @(posedge clk) begin
    if ((item.valid === 1'b1 && item.ready === 1'b1) ||
        (result.valid === 1'b1 && result.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ files.f @@
+incdir+sv
sv/idpc_pkg.sv
sv/idpc_if.sv
sv/idpc_datapath.sv
sv/idpc_controller.sv
sv/implant_decay_pixel_correlator.sv
sv/idpc_checker.sv
tb/tb_implant_decay_pixel_correlator.sv
